// ----- hdl/hierarchical_path_validator_defines.svh -----
// ----------------------------------------------------------------------------
// Hierarchical path validator assertion macros
// Shared concurrent assertion forms for the path validator modules.
// ----------------------------------------------------------------------------
`ifndef HIERARCHICAL_PATH_VALIDATOR_DEFINES_SVH
`define HIERARCHICAL_PATH_VALIDATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HPV_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hpv assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HPV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hpv assertion failed");

`endif

// ----- hdl/hpv_pkg.sv -----
// ----------------------------------------------------------------------------
// Hierarchical path validator package
// Types, verdict codes and the character class shared by the validator.
// ----------------------------------------------------------------------------
package hpv_pkg;

  localparam int MAX_LEN_DEF = 256;
  localparam int CH_W        = 8;
  localparam int VERDICT_W   = 4;
  localparam int EPOS_W      = 8;

  typedef enum logic [3:0] {
    PH_START = 4'b0001,
    PH_SLASH = 4'b0010,
    PH_SEG   = 4'b0100,
    PH_DOTS  = 4'b1000
  } hpv_phase_t;

  typedef enum logic [VERDICT_W-1:0] {
    V_OK       = 4'd0,
    V_TOO_LONG = 4'd1,
    V_NO_LEAD  = 4'd2,
    V_DOUBLE   = 4'd3,
    V_DOTSEG   = 4'd4,
    V_BADCHAR  = 4'd5,
    V_EMPTY    = 4'd6,
    V_LONE     = 4'd7,
    V_ENDDOTS  = 4'd8
  } hpv_verdict_t;

  localparam logic [CH_W-1:0] CH_LOW_A = 8'h61;
  localparam logic [CH_W-1:0] CH_LOW_Z = 8'h7a;
  localparam logic [CH_W-1:0] CH_DIG_0 = 8'h30;
  localparam logic [CH_W-1:0] CH_DIG_9 = 8'h39;
  localparam logic [CH_W-1:0] CH_DASH  = 8'h2d;
  localparam logic [CH_W-1:0] CH_UNDER = 8'h5f;
  localparam logic [CH_W-1:0] CH_DOT   = 8'h2e;
  localparam logic [CH_W-1:0] CH_SLASH = 8'h2f;

  // One request as it leaves the input register.
  typedef struct packed {
    logic            valid;
    logic            end_req;
    logic [CH_W-1:0] ch;
  } hpv_item_t;

  // Verdict for the path closed by an end request.
  typedef struct packed {
    hpv_verdict_t      verdict;
    logic [EPOS_W-1:0] error_position;
  } hpv_result_t;

  function automatic logic char_allowed(input logic [CH_W-1:0] c);
    logic ok;
    ok = ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) ||
         ((c >= CH_DIG_0) && (c <= CH_DIG_9)) ||
         (c == CH_DASH) || (c == CH_UNDER) ||
         (c == CH_DOT) || (c == CH_SLASH);
    return ok;
  endfunction

endpackage

// ----- hdl/hpv_fsm.sv -----
// ----------------------------------------------------------------------------
// Path validator state machine
// Holds the phase, length count and first error, steps them once per byte
// request and forms the verdict when an end request arrives.
// ----------------------------------------------------------------------------
`include "hierarchical_path_validator_defines.svh"

module hpv_fsm #(
  parameter int MAX_LEN = hpv_pkg::MAX_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hpv_pkg::hpv_item_t  step,
  output hpv_pkg::hpv_result_t result
);
  import hpv_pkg::*;

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);

  hpv_phase_t        phase_r,   phase_nxt;
  logic [CNT_W-1:0]  count_r,   count_nxt;
  hpv_verdict_t      err_r,     err_nxt;
  logic [EPOS_W-1:0] err_idx_r, err_idx_nxt;
  logic [EPOS_W-1:0] pos;
  logic              seg_ok;

  assign pos    = EPOS_W'(count_r);
  assign seg_ok = char_allowed(step.ch);

  always_comb begin
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    err_nxt     = err_r;
    err_idx_nxt = err_idx_r;
    if (step.valid && step.end_req) begin
      phase_nxt   = PH_START;
      count_nxt   = '0;
      err_nxt     = V_OK;
      err_idx_nxt = '0;
    end else if (step.valid) begin
      if (count_r < CNT_MAX) begin
        count_nxt = count_r + CNT_W'(1);
      end
      if (err_r == V_OK) begin
        unique case (phase_r)
          PH_START: begin
            if (step.ch != CH_SLASH) err_nxt = V_NO_LEAD;
            else phase_nxt = PH_SLASH;
          end
          PH_SLASH: begin
            if (step.ch == CH_SLASH) begin
              err_nxt = V_DOUBLE;
            end else if (step.ch == CH_DOT) begin
              phase_nxt = PH_DOTS;
            end else if (seg_ok) begin
              phase_nxt = PH_SEG;
            end else begin
              err_nxt     = V_BADCHAR;
              err_idx_nxt = pos;
            end
          end
          PH_SEG: begin
            if (step.ch == CH_SLASH) begin
              phase_nxt = PH_SLASH;
            end else if (seg_ok) begin
              phase_nxt = PH_SEG;
            end else begin
              err_nxt     = V_BADCHAR;
              err_idx_nxt = pos;
            end
          end
          PH_DOTS: begin
            if (step.ch == CH_SLASH) begin
              err_nxt = V_DOTSEG;
            end else if (step.ch == CH_DOT) begin
              phase_nxt = PH_DOTS;
            end else if (seg_ok) begin
              phase_nxt = PH_SEG;
            end else begin
              err_nxt     = V_BADCHAR;
              err_idx_nxt = pos;
            end
          end
          default: phase_nxt = PH_START;
        endcase
      end
    end
  end

  always_comb begin
    result.error_position = '0;
    if (count_r >= CNT_MAX) begin
      result.verdict = V_TOO_LONG;
    end else if (err_r != V_OK) begin
      result.verdict = err_r;
      if (err_r == V_BADCHAR) result.error_position = err_idx_r;
    end else begin
      unique case (phase_r)
        PH_START: result.verdict = V_EMPTY;
        PH_SLASH: result.verdict = (count_r > CNT_W'(1)) ? V_OK : V_LONE;
        PH_SEG:   result.verdict = V_OK;
        PH_DOTS:  result.verdict = V_ENDDOTS;
        default:  result.verdict = V_EMPTY;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_START;
      count_r   <= '0;
      err_r     <= V_OK;
      err_idx_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      err_r     <= err_nxt;
      err_idx_r <= err_idx_nxt;
    end
  end

  `HPV_ASSERT_NEXT(a_end_clears, clk, rst_n, step.valid && step.end_req, phase_r == PH_START && count_r == '0 && err_r == V_OK)
  `HPV_ASSERT_SAME(a_count_sat, clk, rst_n, 1'b1, count_r <= CNT_MAX)
  `HPV_ASSERT_SAME(a_idx_badchar, clk, rst_n, err_idx_r != '0, err_r == V_BADCHAR)

endmodule

// ----- hdl/hierarchical_path_validator.sv -----
// An end request goes from the input register to the result register, which sets out_valid.
// Throughput: one request per cycle unless an end request waits; byte requests give no result
// and never wait on out_ready; an end request waits while a held result is not taken.
// Reset: rst_n is synchronous and active low; it empties both registers and returns the
// path state to the start phase with a zero count and no error.
// ----------------------------------------------------------------------------
// Hierarchical path validator
// Input register, path state machine and result register for checking a
// slash-separated path one byte per request.
// ----------------------------------------------------------------------------
`include "hierarchical_path_validator_defines.svh"

module hierarchical_path_validator #(
  parameter int MAX_LEN = hpv_pkg::MAX_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [hpv_pkg::CH_W-1:0]      in_ch,
  input  logic                          in_end_req,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hpv_pkg::VERDICT_W-1:0] out_verdict,
  output logic [hpv_pkg::EPOS_W-1:0]    out_error_position
);
  import hpv_pkg::*;

  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_end_r;
  logic [CH_W-1:0]   s1_ch_r;
  logic              s1_adv;
  logic              out_valid_r, out_valid_nxt;
  hpv_result_t       out_r;
  hpv_item_t         step;
  hpv_result_t       result;

  assign s1_adv   = s1_valid_r && (!s1_end_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  assign step.valid   = s1_adv;
  assign step.end_req = s1_end_r;
  assign step.ch      = s1_ch_r;

  assign s1_valid_nxt = (in_valid && in_ready) ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (s1_adv && s1_end_r) out_valid_nxt = 1'b1;
  end

  hpv_fsm #(
    .MAX_LEN(MAX_LEN)
  ) u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_ch_r  <= in_ch;
      s1_end_r <= in_end_req;
    end
    if (s1_adv && s1_end_r) begin
      out_r <= result;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_verdict        = out_r.verdict;
  assign out_error_position = out_r.error_position;

  `HPV_ASSERT_SAME(a_pos_only_badchar, clk, rst_n,
    out_valid_r && out_r.verdict != V_BADCHAR, out_r.error_position == '0)
  `HPV_ASSERT_NEXT(a_end_loads_out, clk, rst_n, s1_adv && s1_end_r, out_valid_r)
  `HPV_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_r && !out_ready, out_valid_r)

endmodule

// ----- test/hpv_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Path validator checker
// Watches both channels of the validator, keeps its own copy of the path
// state, predicts the verdict of every end request and compares each
// verdict that leaves the block with the oldest prediction.
// ----------------------------------------------------------------------------
module hpv_checker #(
  parameter int MAX_LEN = hpv_pkg::MAX_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [hpv_pkg::CH_W-1:0]      in_ch,
  input  logic                          in_end_req,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [hpv_pkg::VERDICT_W-1:0] out_verdict,
  input  logic [hpv_pkg::EPOS_W-1:0]    out_error_position,
  output int                            outstanding,
  output int                            fail_count
);
  import hpv_pkg::*;

  hpv_phase_t        seg_phase;
  int                byte_count;
  hpv_verdict_t      held_error;
  logic [EPOS_W-1:0] held_index;
  hpv_result_t       pending_verdicts[$];
  int                errors;

  initial begin
    errors = 0;
  end

  task automatic clear_path();
    seg_phase  = PH_START;
    byte_count = 0;
    held_error = V_OK;
    held_index = '0;
  endtask

  task automatic path_byte(input logic [CH_W-1:0] c);
    logic              legal;
    logic              in_name;
    logic [EPOS_W-1:0] idx;
    legal = ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) ||
            ((c >= CH_DIG_0) && (c <= CH_DIG_9)) ||
            (c == CH_DASH) || (c == CH_UNDER) || (c == CH_DOT) || (c == CH_SLASH);
    in_name = 1'b0;
    idx = EPOS_W'(byte_count);
    if (byte_count < MAX_LEN) byte_count++;
    if (held_error == V_OK) begin
      case (seg_phase)
        PH_START: begin
          if (c == CH_SLASH) seg_phase = PH_SLASH;
          else held_error = V_NO_LEAD;
        end
        PH_SLASH: begin
          if (c == CH_SLASH) held_error = V_DOUBLE;
          else if (c == CH_DOT) seg_phase = PH_DOTS;
          else in_name = 1'b1;
        end
        PH_SEG: begin
          if (c == CH_SLASH) seg_phase = PH_SLASH;
          else in_name = 1'b1;
        end
        default: begin
          if (c == CH_SLASH) held_error = V_DOTSEG;
          else if (c != CH_DOT) in_name = 1'b1;
        end
      endcase
      if (in_name) begin
        if (legal) begin
          seg_phase = PH_SEG;
        end else begin
          held_error = V_BADCHAR;
          held_index = idx;
        end
      end
    end
  endtask

  task automatic close_path(output hpv_result_t r);
    r.error_position = '0;
    if (byte_count >= MAX_LEN) begin
      r.verdict = V_TOO_LONG;
    end else if (held_error != V_OK) begin
      r.verdict = held_error;
      if (held_error == V_BADCHAR) r.error_position = held_index;
    end else begin
      case (seg_phase)
        PH_START: r.verdict = V_EMPTY;
        PH_SLASH: r.verdict = (byte_count > 1) ? V_OK : V_LONE;
        PH_SEG:   r.verdict = V_OK;
        default:  r.verdict = V_ENDDOTS;
      endcase
    end
    clear_path();
  endtask

  always @(posedge clk) begin : watch
    hpv_result_t want;
    hpv_result_t got;
    if (!rst_n) begin
      clear_path();
      pending_verdicts.delete();
    end else begin
      if (in_valid && in_ready) begin
        if (in_end_req) begin
          close_path(want);
          pending_verdicts.push_back(want);
        end else begin
          path_byte(in_ch);
        end
      end
      if (out_valid && out_ready) begin
        got.verdict        = hpv_verdict_t'(out_verdict);
        got.error_position = out_error_position;
        if (pending_verdicts.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: verdict %0d position %0d arrived with none predicted",
                     $realtime, out_verdict, out_error_position);
        end else begin
          want = pending_verdicts.pop_front();
          if (got != want) begin
            errors++;
            if (errors <= 10)
              $display("%0t: wrong verdict: expected %0d position %0d, got %0d position %0d",
                       $realtime, want.verdict, want.error_position,
                       out_verdict, out_error_position);
          end
        end
      end
    end
    outstanding <= pending_verdicts.size();
    fail_count  <= errors;
  end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Path validator testbench
// Drives byte and end requests into the validator, first a handful of
// directed paths and then random paths that are mostly well formed, with
// random stalls on both channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
  import hpv_pkg::*;

  localparam int ITEM_GOAL   = 1300;
  localparam int CYCLE_LIMIT = 200000;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CH_W-1:0]      in_ch = '0;
  logic                 in_end_req = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [VERDICT_W-1:0] out_verdict;
  logic [EPOS_W-1:0]    out_error_position;
  int                   outstanding;
  int                   fail_count;
  int                   items_sent = 0;
  int                   cycles = 0;
  logic [CH_W-1:0]      path_buf[$];
  logic                 quiet;

  assign quiet = (items_sent >= 500) && (items_sent < 800);

  hierarchical_path_validator #(.MAX_LEN(MAX_LEN_DEF)) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_ch              (in_ch),
    .in_end_req         (in_end_req),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_verdict        (out_verdict),
    .out_error_position (out_error_position)
  );

  hpv_checker #(.MAX_LEN(MAX_LEN_DEF)) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_ch              (in_ch),
    .in_end_req         (in_end_req),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_verdict        (out_verdict),
    .out_error_position (out_error_position),
    .outstanding        (outstanding),
    .fail_count         (fail_count)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    out_ready <= quiet || ($urandom_range(99) >= 21);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("hierarchical_path_validator: mismatch");
      $finish;
    end
  end

  task automatic send_req(input logic [CH_W-1:0] c, input logic e);
    logic took;
    while (!quiet && ($urandom_range(99) < 21)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_ch      <= c;
    in_end_req <= e;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end
    items_sent++;
  endtask

  task automatic send_path();
    foreach (path_buf[i]) send_req(path_buf[i], 1'b0);
    send_req(CH_LOW_Z ^ CH_DIG_9, 1'b1);
    path_buf.delete();
  endtask

  task automatic load_text(input string s);
    for (int i = 0; i < s.len(); i++) path_buf.push_back(s[i]);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  function automatic logic [CH_W-1:0] name_char();
    case ($urandom_range(9))
      6, 7:    return CH_W'(CH_DIG_0 + $urandom_range(9));
      8:       return $urandom_range(1) ? CH_DASH : CH_UNDER;
      9:       return CH_DOT;
      default: return CH_W'(CH_LOW_A + $urandom_range(25));
    endcase
  endfunction

  task automatic build_random_path();
    int kind;
    int len;
    int nseg;
    kind = $urandom_range(99);
    if (kind < 2) begin
      len = 250 + $urandom_range(12);
      path_buf.push_back(CH_SLASH);
      for (int i = 1; i < len; i++)
        path_buf.push_back((i % 10 == 0) ? CH_SLASH : CH_W'(CH_LOW_A + $urandom_range(25)));
    end else if (kind < 14) begin
      len = $urandom_range(8);
      if ($urandom_range(1)) path_buf.push_back(CH_SLASH);
      for (int i = 0; i < len; i++) path_buf.push_back(CH_W'($urandom_range(255)));
    end else begin
      nseg = $urandom_range(4);
      path_buf.push_back(CH_SLASH);
      for (int s = 0; s < nseg; s++) begin
        if (s != 0) path_buf.push_back(CH_SLASH);
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) path_buf.push_back(name_char());
      end
      if (nseg != 0 && $urandom_range(3) == 0) path_buf.push_back(CH_SLASH);
      if ($urandom_range(9) < 3) begin
        case ($urandom_range(3))
          0: path_buf[$urandom_range(path_buf.size() - 1)] = CH_W'($urandom_range(255));
          1: path_buf.insert($urandom_range(path_buf.size()), CH_SLASH);
          2: begin
            path_buf.push_back(CH_SLASH);
            repeat ($urandom_range(1, 3)) path_buf.push_back(CH_DOT);
          end
          default: begin
            path_buf.push_back(CH_SLASH);
            path_buf.push_back(CH_DOT);
            path_buf.push_back(CH_DOT);
            path_buf.push_back(CH_SLASH);
            path_buf.push_back(name_char());
          end
        endcase
      end
    end
  endtask

  initial begin
    logic drained;
    drained = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_path();
    load_text("/");
    send_path();
    load_text("//");
    send_path();
    load_text("/.");
    send_path();
    load_text("/../");
    send_path();
    path_buf.push_back(CH_SLASH);
    path_buf.push_back(8'h00);
    send_path();
    path_buf.push_back(8'hff);
    path_buf.push_back(CH_SLASH);
    send_path();
    load_text("/z9_-./");
    send_path();
    drain_results();

    while (items_sent < ITEM_GOAL) begin
      build_random_path();
      send_path();
      if (!drained && items_sent >= 900) begin
        drain_results();
        drained = 1'b1;
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("hierarchical_path_validator: match");
    end else begin
      $display("hierarchical_path_validator: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/hpv_pkg.sv
hdl/hpv_fsm.sv
hdl/hierarchical_path_validator.sv
test/hpv_checker.sv
test/tb.sv
